[hw/rtl/bsd_pkg.sv]
// shared types, codes and the alphabet lookup for the base64 stream decoder
`timescale 1ns / 1ps
`default_nettype none
package bsd_pkg;

  // queue between classifier and result sequencer
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // character codes
  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_INVALID       = 3'd1,
    ERR_AFTER_PAD     = 3'd2,
    ERR_MISPLACED_PAD = 3'd3,
    ERR_TRUNCATED     = 3'd4
  } err_t;

  // one classified character, expanded later into 0..4 result words
  typedef struct packed {
    logic [23:0] word;     // completed group, first byte in the top bits
    logic [1:0]  nbytes;   // decoded bytes to emit
    err_t        err;      // new error to report, ERR_NONE for none
    logic        fin;      // emit an end word
    err_t        end_err;  // error code carried by the end word
  } job_t;

  // {hit, sextet}; hit is low for bytes outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    case (c) inside
      [8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
      [8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h47)};
      [8'h30:8'h39]: r = {1'b1, 6'(c + 8'h04)};
      8'h2B:         r = {1'b1, 6'd62};
      8'h2F:         r = {1'b1, 6'd63};
      default:       r = 7'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bsd_front.sv]
// classifier: accepts characters, tracks group state, pushes jobs to the queue
`timescale 1ns / 1ps
`default_nettype none
module bsd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_char,
  input  wire logic          in_final,
  input  wire logic          q_full,
  output logic               push,
  output bsd_pkg::job_t      push_job
);
  import bsd_pkg::*;

  logic [17:0] acc, acc_next;
  logic [1:0]  gc, gc_next;
  logic [1:0]  pad, pad_next;
  err_t        sticky, sticky_next;

  logic        fire, ws, active;
  logic [6:0]  sv;
  logic [5:0]  v;
  err_t        err_new, job_err;
  logic [1:0]  nbytes;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign sv       = sextet_of(in_char);

  always_comb begin
    ws = (in_char == CharSpace) || (in_char == CharTab) ||
         (in_char == CharCr) || (in_char == CharLf);
    active   = (sticky == ERR_NONE) && !ws;
    err_new  = ERR_NONE;
    v        = 6'd0;
    pad_next = pad;
    acc_next = acc;
    gc_next  = gc;
    nbytes   = 2'd0;
    if (active) begin
      if (in_char == CharPad) begin
        if (gc < 2'd2) err_new = ERR_MISPLACED_PAD;
        else pad_next = pad + 2'd1;
      end else if (pad != 2'd0) begin
        err_new = ERR_AFTER_PAD;
      end else if (!sv[6]) begin
        err_new = ERR_INVALID;
      end else begin
        v = sv[5:0];
      end
      if (err_new == ERR_NONE) begin
        if (gc == 2'd3) begin
          // group closes; pads trim the tail bytes
          case (pad_next)
            2'd0:    nbytes = 2'd3;
            2'd1:    nbytes = 2'd2;
            default: nbytes = 2'd1;
          endcase
          acc_next = 18'd0;
          gc_next  = 2'd0;
        end else begin
          acc_next = {acc[11:0], v};
          gc_next  = gc + 2'd1;
        end
      end
    end
    sticky_next = (err_new != ERR_NONE) ? err_new : sticky;
    job_err     = err_new;
    if (in_final && sticky_next == ERR_NONE && gc_next != 2'd0) begin
      job_err     = ERR_TRUNCATED;
      sticky_next = ERR_TRUNCATED;
    end

    push_job.word    = {acc, v};
    push_job.nbytes  = nbytes;
    push_job.err     = job_err;
    push_job.fin     = in_final;
    push_job.end_err = sticky_next;
    push = fire && ((nbytes != 2'd0) || (job_err != ERR_NONE) || in_final);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= 18'd0;
      gc     <= 2'd0;
      pad    <= 2'd0;
      sticky <= ERR_NONE;
    end else if (fire) begin
      if (in_final) begin
        acc    <= 18'd0;
        gc     <= 2'd0;
        pad    <= 2'd0;
        sticky <= ERR_NONE;
      end else begin
        acc    <= acc_next;
        gc     <= gc_next;
        pad    <= pad_next;
        sticky <= sticky_next;
      end
    end
  end

  // text state is cleared after the final character
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    fire && in_final |=> gc == 2'd0 && sticky == ERR_NONE && pad == 2'd0)
    else $error("state not cleared after final character");

  // the first error holds until the text closes
  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    sticky != ERR_NONE && !(fire && in_final) |=> sticky == $past(sticky))
    else $error("sticky error changed mid-text");

  // a group only closes with three sextets already collected
  a_close_gc: assert property (@(posedge clk) disable iff (rst)
    push && push_job.nbytes != 2'd0 |-> gc == 2'd3)
    else $error("bytes pushed from a partial group");

endmodule
`default_nettype wire

[hw/rtl/bsd_queue.sv]
// short job queue between classifier and result sequencer
`timescale 1ns / 1ps
`default_nettype none
module bsd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  bsd_pkg::job_t      push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output bsd_pkg::job_t      head_job
);
  import bsd_pkg::*;

  job_t           slots [QDepth];
  logic [QAw-1:0] wr_ptr, rd_ptr;
  logic [QAw:0]   count;

  assign full       = (count == (QAw+1)'(QDepth));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bsd_back.sv]
// result sequencer: expands each job into its output words, one per cycle while out_ready is high
`timescale 1ns / 1ps
`default_nettype none
module bsd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  bsd_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_last,
  output logic               out_end,
  output logic [2:0]         out_err
);
  import bsd_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [2:0] cnt;
  logic       last, load, fire;

  assign cnt  = 3'(cur.nbytes) + 3'(cur.err != ERR_NONE) + 3'(cur.fin);
  assign last = (3'(idx) + 3'd1 == cnt);
  assign fire = out_valid && out_ready;
  assign load = !cur_valid || (out_ready && last);
  assign q_pop = load && q_valid;
  assign out_valid = cur_valid;
  assign out_last  = last;

  always_comb begin
    out_byte       = 8'd0;
    out_byte_valid = 1'b0;
    out_end        = 1'b0;
    out_err        = ERR_NONE;
    if (idx < cur.nbytes) begin
      out_byte_valid = 1'b1;
      case (idx)
        2'd0:    out_byte = cur.word[23:16];
        2'd1:    out_byte = cur.word[15:8];
        2'd2:    out_byte = cur.word[7:0];
        default: out_byte = 8'd0;
      endcase
    end else if (cur.err != ERR_NONE && idx == cur.nbytes) begin
      out_err = cur.err;
    end else begin
      out_end = 1'b1;
      out_err = cur.end_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= q_valid;
      idx       <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_job;
  end

  // the word index never runs past the job's word count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> 3'(idx) < cnt)
    else $error("word index past job end");

  // a stalled word keeps its place in the job
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(idx))
    else $error("word index moved under stall");

  // an end word is always the last word of its job
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_end |-> out_last)
    else $error("end word not last");

endmodule
`default_nettype wire

[hw/rtl/base64_stream_decoder.sv]
// top level of the streaming base64 decoder
//
//  port group  dir  word fields (low bit up)
//  s_axis      in   tdata: character[7:0]; tlast: final_req
//  m_axis      out  tdata: data_byte[7:0], error_code[10:8]; tuser: byte_valid[0],
//                   text_end[1]; tlast: run_last
//
// one character is taken per cycle while the queue is not full; the classifier
// settles it in that cycle and queues a job of up to four output words. the
// sequencer sends one word per cycle while m_axis_tready is high; a full group
// of four characters gives at most three bytes. rst is synchronous and clears
// group state, the four-entry queue and the sequencer. an output stall fills
// the queue and then drops s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // character[7:0]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // data_byte[7:0], error_code[10:8], zero fill
  output logic [1:0]       m_axis_tuser,   // byte_valid[0], text_end[1]
  output logic             m_axis_tlast
);
  import bsd_pkg::*;

  logic       q_full, push, q_pop, head_valid;
  job_t       push_job, head_job;
  logic [7:0] out_byte;
  logic       out_byte_valid, out_end;
  logic [2:0] out_err;

  bsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_char  (s_axis_tdata),
    .in_final (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  bsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  bsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (head_valid),
    .q_job          (head_job),
    .q_pop          (q_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (m_axis_tlast),
    .out_end        (out_end),
    .out_err        (out_err)
  );

  assign m_axis_tdata = {5'd0, out_err, out_byte};
  assign m_axis_tuser = {out_end, out_byte_valid};

endmodule
`default_nettype wire
